// ===== hw/rtl/brng_pkg.sv =====
// ----------------------------------------------------------------------------
// brng_pkg
// Shared widths, mixing constants and controller states for the bounded
// xorshift128+ generator.
// ----------------------------------------------------------------------------
package brng_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  bitcnt_t;

  // splitmix64 constants
  localparam word_t GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam word_t MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  // xorshift128+ shifts
  localparam int unsigned XS_SHIFT_A = 23;
  localparam int unsigned XS_SHIFT_B = 18;
  localparam int unsigned XS_SHIFT_C = 5;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEED_A,
    ST_WAIT_A,
    ST_SEED_B,
    ST_WAIT_B,
    ST_DIVISOR,
    ST_WAIT_DIVISOR,
    ST_DRAW,
    ST_WAIT_DRAW,
    ST_DONE
  } brng_state_t;

  // handshake between controller and a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== hw/rtl/brng_req_if.sv =====
// ----------------------------------------------------------------------------
// brng_req_if
// Request channel: valid/ready handshake carrying the exclusive range bound.
// ----------------------------------------------------------------------------
interface brng_req_if;
  import brng_pkg::*;

  logic  valid;
  logic  ready;
  word_t range;

  modport source (output valid, output range, input ready);
  modport sink   (input valid, input range, output ready);

endinterface

// ===== hw/rtl/brng_rsp_if.sv =====
// ----------------------------------------------------------------------------
// brng_rsp_if
// Result channel: valid/ready handshake carrying the bounded random value.
// ----------------------------------------------------------------------------
interface brng_rsp_if;
  import brng_pkg::*;

  logic  valid;
  logic  ready;
  word_t random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);

endinterface

// ===== hw/rtl/brng_serial_mul.sv =====
// ----------------------------------------------------------------------------
// brng_serial_mul
// Bit-serial shift-and-add multiplier, low word of the product, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module brng_serial_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  brng_pkg::word_t      op_a,
  input  brng_pkg::word_t      op_b,
  output brng_pkg::unit_status_t status,
  output brng_pkg::word_t      product
);
  import brng_pkg::*;

  localparam bitcnt_t LAST = bitcnt_t'(DATA_W - 1);

  word_t   mcand_r;
  word_t   mplier_r;
  word_t   acc_r;
  bitcnt_t cnt_r;
  logic    busy_r;
  logic    done_r;

  // control: run one iteration per multiplier bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + bitcnt_t'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: add shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= op_a;
      mplier_r <= op_b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[DATA_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[DATA_W-1:1]};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign product     = acc_r;

endmodule

// ===== hw/rtl/brng_serial_div.sv =====
// ----------------------------------------------------------------------------
// brng_serial_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module brng_serial_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  brng_pkg::word_t      dividend,
  input  brng_pkg::word_t      divisor,
  output brng_pkg::unit_status_t status,
  output brng_pkg::word_t      quotient
);
  import brng_pkg::*;

  localparam bitcnt_t LAST = bitcnt_t'(DATA_W - 1);

  word_t             rem_r;
  word_t             quo_r;
  word_t             den_r;
  bitcnt_t           cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // control: one iteration per quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + bitcnt_t'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // trial subtract of the divisor from the partial remainder
  always_comb begin
    trial = {rem_r, quo_r[DATA_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== hw/rtl/bounded_xorshift128plus_rng.sv =====
// ----------------------------------------------------------------------------
// bounded_xorshift128plus_rng
// Returns a uniform random value below each request's range, from an
// xorshift128+ generator seeded by splitmix64 on first use.
//
//   channel   direction  handshake                payload
//   in_req    sink       in_req.valid/ready       range (64b)
//   out_rsp   source     out_rsp.valid/ready      random_value (64b)
//   cfg       write      cfg_wr_en                cfg_wr_data -> seed (64b)
//
// A range of 0 passes from acceptance through the check and done states
// back to idle and returns 0. Otherwise the serial divider first computes
// the divisor (all ones / range), then each draw is one pass of the serial
// divider; rejected draws repeat. The first nonzero-range request after
// reset first runs splitmix64 seeding (two words, two passes of the serial
// multiplier each). Reset clears the seed and both generator words. One
// request is in work at a time; a finished result waits in the output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
module bounded_xorshift128plus_rng (
  input  logic            clk,
  input  logic            rst_n,
  brng_req_if.sink        in_req,
  brng_rsp_if.source      out_rsp,
  input  logic            cfg_wr_en,
  input  brng_pkg::word_t cfg_wr_data
);
  import brng_pkg::*;

  brng_state_t  state_r;
  brng_state_t  state_nxt;

  word_t        seed_r;
  word_t        gen0_r;
  word_t        gen1_r;
  word_t        range_r;
  word_t        divisor_r;
  word_t        counter_r;
  word_t        mix_r;
  word_t        result_r;
  logic         word_sel_r;
  word_t        out_data_r;
  logic         out_valid_r;

  logic         mul_start;
  word_t        mul_a;
  word_t        mul_b;
  unit_status_t mul_status;
  word_t        mul_product;

  logic         div_start;
  word_t        div_num;
  word_t        div_den;
  unit_status_t div_status;
  word_t        div_quotient;

  word_t        xs_a;
  word_t        xs_next1;
  word_t        xs_raw;
  word_t        mix_out;
  logic         unseeded;
  logic         out_free;
  logic         req_fire;

  // serial arithmetic units
  brng_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .status  (mul_status),
    .product (mul_product)
  );

  brng_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // xorshift128+ step and splitmix64 final mix
  always_comb begin
    xs_a     = gen0_r ^ (gen0_r << XS_SHIFT_A);
    xs_next1 = xs_a ^ gen1_r ^ (xs_a >> XS_SHIFT_B) ^ (gen1_r >> XS_SHIFT_C);
    xs_raw   = xs_next1 + gen1_r;
    mix_out  = mul_product ^ (mul_product >> MIX_SHIFT_C);
  end

  assign unseeded = (gen0_r == '0) && (gen1_r == '0);
  assign out_free = !out_valid_r || out_rsp.ready;
  assign req_fire = in_req.valid && in_req.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (range_r == '0) begin
          state_nxt = ST_DONE;
        end else if (unseeded) begin
          state_nxt = ST_SEED_A;
        end else begin
          state_nxt = ST_DIVISOR;
        end
      end
      ST_SEED_A:  state_nxt = ST_WAIT_A;
      ST_WAIT_A: begin
        if (mul_status.done) begin
          state_nxt = ST_SEED_B;
        end
      end
      ST_SEED_B:  state_nxt = ST_WAIT_B;
      ST_WAIT_B: begin
        if (mul_status.done) begin
          state_nxt = word_sel_r ? ST_DIVISOR : ST_SEED_A;
        end
      end
      ST_DIVISOR: state_nxt = ST_WAIT_DIVISOR;
      ST_WAIT_DIVISOR: begin
        if (div_status.done) begin
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW:    state_nxt = ST_WAIT_DRAW;
      ST_WAIT_DRAW: begin
        if (div_status.done) begin
          state_nxt = (div_quotient >= range_r) ? ST_DRAW : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit starts and operand selection
  always_comb begin
    in_req.ready = 1'b0;
    mul_start    = 1'b0;
    mul_a        = counter_r ^ (counter_r >> MIX_SHIFT_A);
    mul_b        = MIX_MUL_A;
    div_start    = 1'b0;
    div_num      = '1;
    div_den      = range_r;
    unique case (state_r)
      ST_IDLE:    in_req.ready = 1'b1;
      ST_SEED_A:  mul_start = 1'b1;
      ST_SEED_B: begin
        mul_start = 1'b1;
        mul_a     = mix_r ^ (mix_r >> MIX_SHIFT_B);
        mul_b     = MIX_MUL_B;
      end
      ST_DIVISOR: div_start = 1'b1;
      ST_DRAW: begin
        div_start = 1'b1;
        div_num   = xs_raw;
        div_den   = divisor_r;
      end
      default: begin
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      gen0_r      <= '0;
      gen1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      // seeded words land after the second multiply of each splitmix step
      if (state_r == ST_WAIT_B && mul_status.done) begin
        if (word_sel_r) begin
          gen1_r <= mix_out;
        end else begin
          gen0_r <= mix_out;
        end
      end
      // generator advances once per draw
      if (state_r == ST_DRAW) begin
        gen0_r <= gen1_r;
        gen1_r <= xs_next1;
      end
      // output register
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      range_r <= in_req.range;
    end
    if (state_r == ST_CHECK) begin
      counter_r  <= seed_r + GOLDEN_STEP;
      word_sel_r <= 1'b0;
      result_r   <= '0;
    end
    if (state_r == ST_WAIT_A && mul_status.done) begin
      mix_r <= mul_product;
    end
    if (state_r == ST_WAIT_B && mul_status.done) begin
      counter_r  <= counter_r + GOLDEN_STEP;
      word_sel_r <= 1'b1;
    end
    if (state_r == ST_WAIT_DIVISOR && div_status.done) begin
      divisor_r <= div_quotient;
    end
    if (state_r == ST_WAIT_DRAW && div_status.done) begin
      result_r <= div_quotient;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= result_r;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.random_value = out_data_r;

endmodule
